/* sv/gepp_pkg.sv */
// shared constants, types and helpers of the gaussian elimination solver
package gepp_pkg;

	localparam int MAX_N       = 16;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int QUO_W       = DATA_W + FRAC_BITS;
	localparam int STORE_DEPTH = MAX_N * (MAX_N + 1);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = 9;
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam int N_W         = $clog2(MAX_N + 2);
	localparam int RC_W        = $clog2(CNT_W);
	localparam int SIZE_W      = 5;
	localparam int THR_W       = 16;
	localparam int IDX_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_HOMOG    = 2'd2,
		ST_COUNT    = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_LOAD, S_RECOL,
		S_PS_RD, S_PS_CMP, S_PS_CHK,
		S_SW_RD1, S_SW_RD2, S_SW_WR1, S_SW_WR2,
		S_NM_RD, S_NM_DIV, S_NM_WAIT,
		S_EL_FRD, S_EL_F, S_EL_RDK, S_EL_MUL, S_EL_SH, S_EL_WR,
		S_BS_XRD, S_BS_X, S_BS_RDA, S_BS_MUL, S_BS_SH, S_BS_WR,
		S_EM_RD, S_EM_OUT
	} state_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] num;
		logic signed [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic              valid;
		logic              neg;
		logic [DATA_W-1:0] rem;
		logic [QUO_W-1:0]  num;
		logic [QUO_W-1:0]  quo;
		logic [DATA_W-1:0] den;
	} div_stage_t;

	function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

endpackage

/* sv/gepp_div_cell.sv */
// one restoring division cell: settles one quotient bit and passes on
module gepp_div_cell import gepp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  div_stage_t d_in,
	output div_stage_t d_out
);

	logic [DATA_W:0] trial;
	logic            fits;
	div_stage_t      nxt;
	div_stage_t      stage_q;

	always_comb begin
		trial = {d_in.rem, d_in.num[QUO_W-1]};
		fits  = trial >= {1'b0, d_in.den};
		nxt      = d_in;
		nxt.num  = {d_in.num[QUO_W-2:0], 1'b0};
		nxt.quo  = {d_in.quo[QUO_W-2:0], fits};
		nxt.rem  = fits ? DATA_W'(trial - {1'b0, d_in.den}) : trial[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= nxt;
		end
	end

	assign d_out = stage_q;

endmodule

/* sv/gepp_div_chain.sv */
// fixed-point divider built from a row of restoring division cells
module gepp_div_chain import gepp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((64'd1 << (DATA_W - 1)) - 64'd1);
	localparam logic [QUO_W-1:0] NEG_LIM = POS_LIM + QUO_W'(1);

	div_stage_t link [QUO_W+1];
	div_rsp_t   rsp_q;
	div_stage_t tail;

	always_comb begin
		link[0].valid = req.valid;
		link[0].neg   = req.num[DATA_W-1] ^ req.den[DATA_W-1];
		link[0].rem   = '0;
		link[0].num   = {mag32(req.num), {FRAC_BITS{1'b0}}};
		link[0].quo   = '0;
		link[0].den   = mag32(req.den);
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_cell
		gepp_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.d_in  (link[g]),
			.d_out (link[g+1])
		);
	end

	assign tail = link[QUO_W];

	// sign and saturation after the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else begin
			rsp_q.valid <= tail.valid;
			if (!tail.neg) begin
				rsp_q.quo <= (tail.quo > POS_LIM) ? DATA_W'(POS_LIM) : DATA_W'(tail.quo);
			end else begin
				rsp_q.quo <= (tail.quo > NEG_LIM) ? DATA_W'(NEG_LIM) : DATA_W'(-tail.quo);
			end
		end
	end

	assign rsp = rsp_q;

endmodule

/* sv/gauss_elim_partial_pivot_solver_core.sv */
// loading takes one element per cycle while no config write is offered; the solve runs on one
// memory port through pivot search, row swap, normalisation in the 48-cell divider chain and
// elimination for each column, then back substitution row by row, then one result at a time.
// throughput: one system at a time, input held off from the final element to the last result
// reset: load count and column cleared, all-b-zero set, size 4, threshold 1, no result pending;
// matrix memory is not cleared
module gauss_elim_partial_pivot_solver_core import gepp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,   // [31:0] element
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,   // [31:0] x_value, [35:32] x_index, [39:36] zero
	output logic [1:0]            m_tuser,   // [1:0] status
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [SIZE_W-1:0]   sz_q;
	logic [THR_W-1:0]    thr_q;
	logic [CNT_W-1:0]    lc_q, lc_next;
	logic [N_W-1:0]      col_q;
	logic                abz_q;
	logic [N_W-1:0]      k_q, i_q, j_q, p_q, e_q;
	status_t             status_q;
	logic [RC_W-1:0]     rc_cnt_q;
	logic [N_W-1:0]      rc_rem_q, rc_next;
	logic [N_W:0]        rc_trial;

	logic [DATA_W-1:0]        best_q;
	logic signed [DATA_W-1:0] piv_q, tmp_q, f_q, rdata_q, mq_s2;
	logic signed [2*DATA_W-1:0] prod_s1;

	logic                 out_valid_q, out_last_q;
	logic [DATA_W-1:0]    out_value_q;
	logic [IDX_W-1:0]     out_index_q;
	status_t              out_status_q;

	logic [N_W-1:0]   n, w;
	logic [CNT_W-1:0] full_cnt;
	logic             s_acc, cfg_acc, load_out, take;
	logic [DATA_W-1:0] cand_mag;

	logic [DATA_W-1:0]  mem_q [STORE_DEPTH];
	logic               mem_re, mem_we, use_lc;
	logic [ADDR_W-1:0]  mem_addr;
	logic [DATA_W-1:0]  mem_wdata;
	logic [N_W-1:0]     row_sel, col_sel;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [DATA_W:0]     diff;
	logic signed [DATA_W-1:0]   sub_sat;
	logic signed [2*DATA_W-1:0] prod_sh;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [N_W-1:0] r,
		input logic [N_W-1:0] c, input logic [N_W-1:0] wd);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(wd) + ADDR_W'(c));
	endfunction

	gepp_div_chain u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		if (sz_q == '0) begin
			n = N_W'(1);
		end else if (sz_q > SIZE_W'(MAX_N)) begin
			n = N_W'(MAX_N);
		end else begin
			n = N_W'(sz_q);
		end
		w        = n + N_W'(1);
		full_cnt = CNT_W'(n) * CNT_W'(w);
		lc_next  = (lc_q < CNT_W'(CNT_MAX)) ? lc_q + CNT_W'(1) : lc_q;
		cand_mag = mag32(rdata_q);
		take     = (i_q == k_q) || (cand_mag > best_q);
		rc_trial = {rc_rem_q, lc_q[rc_cnt_q]};
		rc_next  = (rc_trial >= {1'b0, w}) ? N_W'(rc_trial - {1'b0, w}) : rc_trial[N_W-1:0];
		diff     = {rdata_q[DATA_W-1], rdata_q} - {mq_s2[DATA_W-1], mq_s2};
		// overflow shows as the two top bits differing
		if (diff[DATA_W] != diff[DATA_W-1]) begin
			sub_sat = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			sub_sat = diff[DATA_W-1:0];
		end
		// truncate toward zero when dropping the fraction bits
		prod_sh = (prod_s1 + (prod_s1[2*DATA_W-1] ? (2*DATA_W)'((1 << FRAC_BITS) - 1)
			: (2*DATA_W)'(0))) >>> FRAC_BITS;
	end

	assign s_acc    = s_tvalid && s_tready;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign load_out = (state_q == S_EM_OUT) && (!out_valid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (cfg_acc && cfg_index == REG_SIZE) begin
					state_d = S_RECOL;
				end else if (s_acc && s_tlast) begin
					state_d = (lc_next != full_cnt) ? S_EM_RD : S_PS_RD;
				end
			end
			S_RECOL:  if (rc_cnt_q == '0) state_d = S_LOAD;
			S_PS_RD:  state_d = S_PS_CMP;
			S_PS_CMP: state_d = (i_q == n - N_W'(1)) ? S_PS_CHK : S_PS_RD;
			S_PS_CHK: begin
				if (best_q <= DATA_W'(thr_q)) begin
					state_d = S_EM_RD;
				end else if (p_q != k_q) begin
					state_d = S_SW_RD1;
				end else begin
					state_d = S_NM_RD;
				end
			end
			S_SW_RD1: state_d = S_SW_RD2;
			S_SW_RD2: state_d = S_SW_WR1;
			S_SW_WR1: state_d = S_SW_WR2;
			S_SW_WR2: state_d = (j_q == n) ? S_NM_RD : S_SW_RD1;
			S_NM_RD:  state_d = S_NM_DIV;
			S_NM_DIV: state_d = S_NM_WAIT;
			S_NM_WAIT: begin
				if (div_rsp.valid) state_d = (j_q == n) ? S_EL_FRD : S_NM_RD;
			end
			S_EL_FRD: begin
				if (i_q < n) begin
					state_d = S_EL_F;
				end else if (k_q + N_W'(1) == n) begin
					state_d = abz_q ? S_EM_RD : S_BS_XRD;
				end else begin
					state_d = S_PS_RD;
				end
			end
			S_EL_F:   state_d = S_EL_RDK;
			S_EL_RDK: state_d = S_EL_MUL;
			S_EL_MUL: state_d = S_EL_SH;
			S_EL_SH:  state_d = S_EL_WR;
			S_EL_WR:  state_d = (j_q == n) ? S_EL_FRD : S_EL_RDK;
			S_BS_XRD: state_d = S_BS_X;
			S_BS_X:   state_d = (i_q == '0) ? S_EM_RD : S_BS_RDA;
			S_BS_RDA: state_d = S_BS_MUL;
			S_BS_MUL: state_d = S_BS_SH;
			S_BS_SH:  state_d = S_BS_WR;
			S_BS_WR:  state_d = (j_q == i_q - N_W'(1)) ? S_BS_XRD : S_BS_RDA;
			S_EM_RD:  state_d = S_EM_OUT;
			S_EM_OUT: begin
				if (load_out) state_d = (e_q == n - N_W'(1)) ? S_LOAD : S_EM_RD;
			end
			default:  state_d = S_LOAD;
		endcase
	end

	// outputs and memory port
	always_comb begin
		s_tready  = 1'b0;
		cfg_ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		use_lc    = 1'b0;
		row_sel   = '0;
		col_sel   = '0;
		mem_wdata = '0;
		div_req   = '0;
		case (state_q)
			S_LOAD: begin
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
				use_lc    = 1'b1;
				mem_we    = s_acc && (lc_q < CNT_W'(STORE_DEPTH));
				mem_wdata = s_tdata;
			end
			S_PS_RD: begin
				mem_re = 1'b1; row_sel = i_q; col_sel = k_q;
			end
			S_SW_RD1: begin
				mem_re = 1'b1; row_sel = k_q; col_sel = j_q;
			end
			S_SW_RD2: begin
				mem_re = 1'b1; row_sel = p_q; col_sel = j_q;
			end
			S_SW_WR1: begin
				mem_we = 1'b1; row_sel = k_q; col_sel = j_q; mem_wdata = rdata_q;
			end
			S_SW_WR2: begin
				mem_we = 1'b1; row_sel = p_q; col_sel = j_q; mem_wdata = tmp_q;
			end
			S_NM_RD: begin
				mem_re = 1'b1; row_sel = k_q; col_sel = j_q;
			end
			S_NM_DIV: begin
				div_req.valid = 1'b1;
				div_req.num   = rdata_q;
				div_req.den   = piv_q;
			end
			S_NM_WAIT: begin
				mem_we = div_rsp.valid; row_sel = k_q; col_sel = j_q; mem_wdata = div_rsp.quo;
			end
			S_EL_FRD: begin
				mem_re = i_q < n; row_sel = i_q; col_sel = k_q;
			end
			S_EL_RDK: begin
				mem_re = 1'b1; row_sel = k_q; col_sel = j_q;
			end
			S_EL_MUL: begin
				mem_re = 1'b1; row_sel = i_q; col_sel = j_q;
			end
			S_EL_WR: begin
				mem_we = 1'b1; row_sel = i_q; col_sel = j_q; mem_wdata = sub_sat;
			end
			S_BS_XRD: begin
				mem_re = 1'b1; row_sel = i_q; col_sel = n;
			end
			S_BS_RDA: begin
				mem_re = 1'b1; row_sel = j_q; col_sel = i_q;
			end
			S_BS_MUL: begin
				mem_re = 1'b1; row_sel = j_q; col_sel = n;
			end
			S_BS_WR: begin
				mem_we = 1'b1; row_sel = j_q; col_sel = n; mem_wdata = sub_sat;
			end
			S_EM_RD: begin
				mem_re = 1'b1; row_sel = e_q; col_sel = n;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
		mem_addr = use_lc ? lc_q[ADDR_W-1:0] : cell_addr(row_sel, col_sel, w);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[mem_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			sz_q        <= SIZE_W'(4);
			thr_q       <= THR_W'(1);
			lc_q        <= '0;
			col_q       <= '0;
			abz_q       <= 1'b1;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			p_q         <= '0;
			e_q         <= '0;
			status_q    <= ST_OK;
			rc_cnt_q    <= '0;
			rc_rem_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (cfg_acc) begin
						case (cfg_index)
							REG_SIZE: begin
								sz_q     <= cfg_data[SIZE_W-1:0];
								rc_cnt_q <= RC_W'(CNT_W - 1);
								rc_rem_q <= '0;
							end
							REG_THRESH: thr_q <= cfg_data[THR_W-1:0];
							default: thr_q <= thr_q;
						endcase
					end else if (s_acc) begin
						if (col_q == n && mag32(s_tdata) > DATA_W'(thr_q)) abz_q <= 1'b0;
						if (lc_q < CNT_W'(CNT_MAX)) col_q <= (col_q == n) ? '0 : col_q + N_W'(1);
						lc_q <= lc_next;
						if (s_tlast) begin
							if (lc_next != full_cnt) begin
								status_q <= ST_COUNT;
								e_q      <= '0;
							end else begin
								k_q <= '0;
								i_q <= '0;
							end
						end
					end
				end
				S_RECOL: begin
					// remainder of the load count by the row width, one bit a cycle
					rc_rem_q <= rc_next;
					rc_cnt_q <= rc_cnt_q - RC_W'(1);
					if (rc_cnt_q == '0) col_q <= rc_next;
				end
				S_PS_CMP: begin
					if (take) p_q <= i_q;
					if (i_q != n - N_W'(1)) i_q <= i_q + N_W'(1);
				end
				S_PS_CHK: begin
					if (best_q <= DATA_W'(thr_q)) begin
						status_q <= ST_SINGULAR;
						e_q      <= '0;
					end else begin
						j_q <= k_q;
					end
				end
				S_SW_WR2: j_q <= (j_q == n) ? k_q : j_q + N_W'(1);
				S_NM_WAIT: begin
					if (div_rsp.valid) begin
						if (j_q == n) begin
							i_q <= k_q + N_W'(1);
						end else begin
							j_q <= j_q + N_W'(1);
						end
					end
				end
				S_EL_FRD: begin
					if (i_q >= n) begin
						k_q <= k_q + N_W'(1);
						if (k_q + N_W'(1) == n) begin
							if (abz_q) begin
								status_q <= ST_HOMOG;
								e_q      <= '0;
							end else begin
								i_q <= n - N_W'(1);
							end
						end else begin
							i_q <= k_q + N_W'(1);
						end
					end
				end
				S_EL_F: j_q <= k_q + N_W'(1);
				S_EL_WR: begin
					if (j_q == n) begin
						i_q <= i_q + N_W'(1);
					end else begin
						j_q <= j_q + N_W'(1);
					end
				end
				S_BS_X: begin
					if (i_q == '0) begin
						status_q <= ST_OK;
						e_q      <= '0;
					end else begin
						j_q <= '0;
					end
				end
				S_BS_WR: begin
					if (j_q == i_q - N_W'(1)) begin
						i_q <= i_q - N_W'(1);
					end else begin
						j_q <= j_q + N_W'(1);
					end
				end
				S_EM_OUT: begin
					if (load_out) begin
						if (e_q == n - N_W'(1)) begin
							lc_q  <= '0;
							col_q <= '0;
							abz_q <= 1'b1;
						end else begin
							e_q <= e_q + N_W'(1);
						end
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= f_q * rdata_q;
		// the shifted product fits only if its upper bits all match the sign
		if (!prod_sh[2*DATA_W-1] && (|prod_sh[2*DATA_W-2:DATA_W-1])) begin
			mq_s2 <= {1'b0, {(DATA_W-1){1'b1}}};
		end else if (prod_sh[2*DATA_W-1] && !(&prod_sh[2*DATA_W-2:DATA_W-1])) begin
			mq_s2 <= {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			mq_s2 <= prod_sh[DATA_W-1:0];
		end
		if (state_q == S_PS_CMP && take) begin
			best_q <= cand_mag;
			piv_q  <= rdata_q;
		end
		if (state_q == S_SW_RD2) tmp_q <= rdata_q;
		if (state_q == S_EL_F || state_q == S_BS_X) f_q <= rdata_q;
		if (load_out) begin
			out_value_q  <= (status_q == ST_OK) ? rdata_q : '0;
			out_index_q  <= e_q[IDX_W-1:0];
			out_status_q <= status_q;
			out_last_q   <= (e_q == n - N_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_index_q, out_value_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	a_clear_after_solve: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && e_q == n - N_W'(1)) |=> (lc_q == '0 && abz_q && state_q == S_LOAD))
		else $error("load state not cleared after final result");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[DATA_W-1:0] == '0))
		else $error("non-zero value with error status");

	a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.valid |-> (state_q == S_NM_WAIT))
		else $error("divider result outside normalisation wait");

endmodule
